// ===== sv/rk4_coupled_plant_step_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the RK4 coupled plant step block
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef RK4_COUPLED_PLANT_STEP_MACROS_SVH
`define RK4_COUPLED_PLANT_STEP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define RK4CP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RK4CP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rk4cp_pkg.sv =====
// ---------------------------------------------------------------------------
// RK4 coupled plant package
// Types, constants and fixed-point helpers shared by the datapath modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rk4cp_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int WORD_W          = 32;
    localparam int NUM_STATE       = 8;
    localparam int NUM_LANES       = 2;
    localparam int DERIV_LAT       = 9;
    localparam int CORDIC_ITERS    = 16;
    localparam int ITERS_PER_STAGE = 4;

    // Configuration register indexes and reset values.
    localparam logic [1:0] REG_STEP_WIDTH = 2'd0;
    localparam logic [1:0] REG_GRAVITY    = 2'd1;
    localparam logic [1:0] REG_PLANT_GAIN = 2'd2;

    localparam logic [16:0] STEP_WIDTH_RST = 17'd3277;
    localparam logic [20:0] GRAVITY_RST    = 21'd642685;
    localparam logic [17:0] PLANT_GAIN_RST = 18'd64933;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef word_t [NUM_STATE-1:0] vec_t;

    typedef struct packed {
        logic  clip;
        word_t val;
    } sat_t;

    typedef struct packed {
        logic signed [33:0] cx;
        logic signed [33:0] cy;
        logic signed [33:0] cz;
    } cordic_t;

    // Sine constants (Q30 CORDIC, phase in 32-bit turns).
    localparam word_t              INV_TWO_PI_Q32 = 32'sd683565276;
    localparam logic signed [63:0] HALF_PI_Q29    = 64'sd843314857;
    localparam logic signed [33:0] CORDIC_K       = 34'sd652032874;
    localparam logic signed [32:0] FOLD_LIMIT     = 33'sd1073741824;
    localparam logic signed [32:0] HALF_TURN      = 33'sd2147483648;
    localparam logic signed [33:0] SIN_ROUND      = 34'sd1 <<< (29 - FRAC_BITS);

    localparam logic signed [33:0] ATAN_Q30 [CORDIC_ITERS] = '{
        34'sd843314857, 34'sd497837830, 34'sd263043837, 34'sd133525159,
        34'sd67021688,  34'sd33543515,  34'sd16775851,  34'sd8388438,
        34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
        34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768
    };

    // Final weighted sum: floor(w / 6) done as a split divide by three.
    localparam int                SPLIT_W         = 18;
    localparam logic [37:0]       FINAL_BIAS      = 38'd51539607552;
    localparam logic signed [47:0] FINAL_BIAS_DIV3 = 48'sd17179869184;
    localparam logic [35:0]       DIV3_HI_MUL     = 36'd87381;
    localparam logic [40:0]       DIV3_RECIP      = 41'd699051;
    localparam int                DIV3_SHIFT      = 21;

    function automatic sat_t sat48(input logic signed [47:0] v);
        sat_t r;
        if (v > 48'sd2147483647) begin
            r.clip = 1'b1;
            r.val  = 32'sh7FFFFFFF;
        end else if (v < -48'sd2147483648) begin
            r.clip = 1'b1;
            r.val  = 32'sh80000000;
        end else begin
            r.clip = 1'b0;
            r.val  = v[WORD_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [63:0] smul(input word_t a, input word_t b);
        logic signed [63:0] ea;
        logic signed [63:0] eb;
        ea = a;
        eb = b;
        return ea * eb;
    endfunction

    // Round half up by FRAC_BITS (plus one when extra is set), then saturate.
    function automatic sat_t mulr(input logic signed [63:0] p, input logic extra);
        logic signed [64:0] t;
        logic signed [64:0] s;
        t = 65'(p) + (extra ? (65'sd1 <<< FRAC_BITS) : (65'sd1 <<< (FRAC_BITS - 1)));
        s = extra ? (t >>> (FRAC_BITS + 1)) : (t >>> FRAC_BITS);
        return sat48(s[47:0]);
    endfunction

    // One RK4 stage point: x + h*k scaled, both steps saturating.
    function automatic sat_t stage_point(input word_t x, input word_t k,
                                         input logic [16:0] h, input logic extra);
        word_t hw;
        sat_t  m;
        sat_t  s;
        hw = {15'd0, h};
        m  = mulr(smul(hw, k), extra);
        s  = sat48(48'(x) + 48'(m.val));
        s.clip = s.clip | m.clip;
        return s;
    endfunction

    function automatic cordic_t cordic_rot(input cordic_t c, input logic [3:0] i);
        cordic_t r;
        if (c.cz >= 0) begin
            r.cx = c.cx - (c.cy >>> i);
            r.cy = c.cy + (c.cx >>> i);
            r.cz = c.cz - ATAN_Q30[i];
        end else begin
            r.cx = c.cx + (c.cy >>> i);
            r.cy = c.cy - (c.cx >>> i);
            r.cz = c.cz + ATAN_Q30[i];
        end
        return r;
    endfunction

endpackage

// ===== sv/rk4_coupled_plant_step.sv =====
// ---------------------------------------------------------------------------
// RK4 coupled plant step
// One classic fourth-order Runge-Kutta step of an eight-state coupled plant.
// ---------------------------------------------------------------------------
// Usage: each input transaction on the s_ channel carries the plant state
// x1..x8 and the two drives in Q16.16; each output transaction on the m_
// channel carries the state after one step of width h, with m_tuser[0] set
// when any saturation occurred along the way. Every input transaction gives
// exactly one output transaction, in order.
// Throughput is one transaction per clock cycle while the receiver does not
// stall. From the accepting edge to m_tvalid a transaction passes four
// derivative evaluations of nine stages each, one stage-point stage after
// each of the first three, and three stages for the final weighted sum,
// which divides by six with a split reciprocal multiply.
// The whole pipeline advances together. When the receiver stalls with a
// result held in the output register, every stage freezes and s_tready
// drops; nothing is lost or repeated, and bubbles stay where they are.
// Reset (aresetn low, synchronous) clears all valid bits and restores the step
// width, gravity and gain registers to 0.05, 9.8066 and 0.9908. The user must
// write the configuration port only with no transaction in flight (unchecked).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rk4_coupled_plant_step_macros.svh"

module rk4_coupled_plant_step (
    input  logic         aclk,
    input  logic         aresetn,
    // Input stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata: pos_a, vel_a, ang_a, rate_a, pos_b, vel_b, ang_b, rate_b,
    //          drive_a, drive_b (32 bits each, lowest bits first)
    input  logic [319:0] s_tdata,
    // Result stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata: next_pos_a, next_vel_a, next_ang_a, next_rate_a, next_pos_b,
    //          next_vel_b, next_ang_b, next_rate_b (32 bits each)
    output logic [255:0] m_tdata,
    // m_tuser: saturated
    output logic [0:0]   m_tuser,
    // Configuration writes.
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [20:0]  cfg_wdata
);
    import rk4cp_pkg::*;

    // Register stage positions along the pipeline.
    localparam int P_K1  = DERIV_LAT;
    localparam int P_ST2 = P_K1 + 1;
    localparam int P_K2  = P_ST2 + DERIV_LAT;
    localparam int P_ST3 = P_K2 + 1;
    localparam int P_K3  = P_ST3 + DERIV_LAT;
    localparam int P_ST4 = P_K3 + 1;
    localparam int P_K4  = P_ST4 + DERIV_LAT;
    localparam int P_F1  = P_K4 + 1;
    localparam int P_F2  = P_F1 + 1;
    localparam int P_OUT = P_F2 + 1;

    logic [16:0] step_width_reg;
    logic [20:0] gravity_reg;
    logic [17:0] plant_gain_reg;

    logic        pipe_en;
    logic [P_OUT:0] vp_reg;

    vec_t  xp_reg [0:P_F2];
    word_t ua_reg [0:P_ST4];
    word_t ub_reg [0:P_ST4];
    logic [P_F2:0] fl_reg;
    logic [P_F2:0] fl_next;

    vec_t  st2_reg, st3_reg, st4_reg;
    vec_t  k1p_reg [P_K1+1:P_K4];
    vec_t  k2p_reg [P_K2+1:P_K4];
    vec_t  k3p_reg [P_K3+1:P_K4];

    logic signed [53:0] hs_reg [NUM_STATE];
    logic [35:0]        a_reg  [NUM_STATE];
    logic [19:0]        v_reg  [NUM_STATE];
    vec_t               m_data_reg;
    logic               m_sat_reg;

    vec_t  k1_d, k2_d, k3_d, k4_d;
    logic  k1_clip, k2_clip, k3_clip, k4_clip;

    vec_t  st2_c, st3_c, st4_c;
    logic  st2_clip, st3_clip, st4_clip;
    logic signed [53:0] hs_c [NUM_STATE];
    logic [35:0]        a_c  [NUM_STATE];
    logic [19:0]        v_c  [NUM_STATE];
    vec_t               out_c;
    logic               out_clip;

    // The pipeline moves whenever the output register is empty or is read.
    assign pipe_en  = !vp_reg[P_OUT] || m_tready;
    assign s_tready = pipe_en;
    assign m_tvalid = vp_reg[P_OUT];
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_sat_reg;

    // Configuration registers; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_width_reg <= STEP_WIDTH_RST;
            gravity_reg    <= GRAVITY_RST;
            plant_gain_reg <= PLANT_GAIN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_STEP_WIDTH: step_width_reg <= cfg_wdata[16:0];
                REG_GRAVITY:    gravity_reg    <= cfg_wdata;
                REG_PLANT_GAIN: plant_gain_reg <= cfg_wdata[17:0];
                default:        ;
            endcase
        end
    end

    // Valid bits travel with the data through every stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_reg <= '0;
        end else if (pipe_en) begin
            vp_reg <= {vp_reg[P_OUT-1:0], s_tvalid};
        end
    end

    // Four derivative evaluations, one per RK4 stage point.
    rk4cp_deriv u_deriv_k1 (
        .aclk(aclk), .en(pipe_en), .x_i(xp_reg[0]),
        .drive_a_i(ua_reg[0]), .drive_b_i(ub_reg[0]),
        .gravity_i(gravity_reg), .plant_gain_i(plant_gain_reg),
        .d_o(k1_d), .clip_o(k1_clip)
    );

    rk4cp_deriv u_deriv_k2 (
        .aclk(aclk), .en(pipe_en), .x_i(st2_reg),
        .drive_a_i(ua_reg[P_ST2]), .drive_b_i(ub_reg[P_ST2]),
        .gravity_i(gravity_reg), .plant_gain_i(plant_gain_reg),
        .d_o(k2_d), .clip_o(k2_clip)
    );

    rk4cp_deriv u_deriv_k3 (
        .aclk(aclk), .en(pipe_en), .x_i(st3_reg),
        .drive_a_i(ua_reg[P_ST3]), .drive_b_i(ub_reg[P_ST3]),
        .gravity_i(gravity_reg), .plant_gain_i(plant_gain_reg),
        .d_o(k3_d), .clip_o(k3_clip)
    );

    rk4cp_deriv u_deriv_k4 (
        .aclk(aclk), .en(pipe_en), .x_i(st4_reg),
        .drive_a_i(ua_reg[P_ST4]), .drive_b_i(ub_reg[P_ST4]),
        .gravity_i(gravity_reg), .plant_gain_i(plant_gain_reg),
        .d_o(k4_d), .clip_o(k4_clip)
    );

    // Stage points: x + h/2*k1, x + h/2*k2 and x + h*k3.
    always_comb begin
        sat_t sp;
        st2_clip = 1'b0;
        st3_clip = 1'b0;
        st4_clip = 1'b0;
        for (int i = 0; i < NUM_STATE; i++) begin
            sp       = stage_point(xp_reg[P_K1][i], k1_d[i], step_width_reg, 1'b1);
            st2_c[i] = sp.val;
            st2_clip = st2_clip | sp.clip;
            sp       = stage_point(xp_reg[P_K2][i], k2_d[i], step_width_reg, 1'b1);
            st3_c[i] = sp.val;
            st3_clip = st3_clip | sp.clip;
            sp       = stage_point(xp_reg[P_K3][i], k3_d[i], step_width_reg, 1'b0);
            st4_c[i] = sp.val;
            st4_clip = st4_clip | sp.clip;
        end
    end

    // Clip flags join the running flag where each part completes.
    always_comb begin
        fl_next        = {fl_reg[P_F2-1:0], 1'b0};
        fl_next[P_ST2] = fl_reg[P_ST2-1] | k1_clip | st2_clip;
        fl_next[P_ST3] = fl_reg[P_ST3-1] | k2_clip | st3_clip;
        fl_next[P_ST4] = fl_reg[P_ST4-1] | k3_clip | st4_clip;
        fl_next[P_F1]  = fl_reg[P_F1-1] | k4_clip;
    end

    // Final combination: q = floor((h*S + 3*2^16) / (6*2^16)), with the
    // exact weighted sum S. The division by six drops 16 bits plus one, then
    // divides a biased non-negative value by three in two steps.
    always_comb begin
        word_t              xw, w1, w2, w3, w4;
        logic signed [35:0] s36;
        logic signed [53:0] se, he, wsum;
        logic [37:0]        u;
        logic [18:0]        hi;
        logic [40:0]        fp;
        logic signed [47:0] q48;
        sat_t               r;
        out_clip = 1'b0;
        for (int i = 0; i < NUM_STATE; i++) begin
            // F1: weighted sum and the product with h.
            w1 = k1p_reg[P_K4][i];
            w2 = k2p_reg[P_K4][i];
            w3 = k3p_reg[P_K4][i];
            w4 = k4_d[i];
            s36 = 36'(w1) + (36'(w2) <<< 1) + (36'(w3) <<< 1) + 36'(w4);
            se  = s36;
            he  = {37'd0, step_width_reg};
            hs_c[i] = se * he;
            // F2: round, bias, split into high and low halves.
            wsum = hs_reg[i] + (54'sd3 <<< FRAC_BITS);
            u    = {wsum[53], wsum[53:FRAC_BITS + 1]} + FINAL_BIAS;
            hi   = u[SPLIT_W +: 19];
            a_c[i] = {17'd0, hi} * DIV3_HI_MUL;
            v_c[i] = {1'b0, hi} + {2'b0, u[SPLIT_W-1:0]};
            // F3: finish the divide and add to the state.
            fp  = {21'd0, v_reg[i]} * DIV3_RECIP;
            q48 = signed'({12'd0, a_reg[i]}) + signed'({28'd0, fp[DIV3_SHIFT +: 20]})
                  - FINAL_BIAS_DIV3;
            xw  = xp_reg[P_F2][i];
            r   = sat48(48'(xw) + q48);
            out_c[i] = r.val;
            out_clip = out_clip | r.clip;
        end
    end

    // Datapath registers; all move together with the valid bits.
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            xp_reg[0] <= s_tdata[NUM_STATE*WORD_W-1:0];
            ua_reg[0] <= s_tdata[NUM_STATE*WORD_W +: WORD_W];
            ub_reg[0] <= s_tdata[(NUM_STATE+1)*WORD_W +: WORD_W];
            for (int p = 1; p <= P_F2; p++) begin
                xp_reg[p] <= xp_reg[p-1];
            end
            for (int p = 1; p <= P_ST4; p++) begin
                ua_reg[p] <= ua_reg[p-1];
                ub_reg[p] <= ub_reg[p-1];
            end
            fl_reg <= fl_next;

            st2_reg <= st2_c;
            st3_reg <= st3_c;
            st4_reg <= st4_c;

            k1p_reg[P_K1+1] <= k1_d;
            for (int p = P_K1 + 2; p <= P_K4; p++) begin
                k1p_reg[p] <= k1p_reg[p-1];
            end
            k2p_reg[P_K2+1] <= k2_d;
            for (int p = P_K2 + 2; p <= P_K4; p++) begin
                k2p_reg[p] <= k2p_reg[p-1];
            end
            k3p_reg[P_K3+1] <= k3_d;
            for (int p = P_K3 + 2; p <= P_K4; p++) begin
                k3p_reg[p] <= k3p_reg[p-1];
            end

            hs_reg     <= hs_c;
            a_reg      <= a_c;
            v_reg      <= v_c;
            m_data_reg <= out_c;
            m_sat_reg  <= fl_reg[P_F2] | out_clip;
        end
    end

    // A frozen pipeline keeps every valid bit where it was.
    `RK4CP_ASSERT_NEXT(a_stall_holds, !pipe_en, $stable(vp_reg), "valid bits moved in a stall")
    // An item in the last datapath stage reaches the output when the pipe moves.
    `RK4CP_ASSERT_NEXT(a_last_to_out, pipe_en && vp_reg[P_F2], m_tvalid, "result lost")
    // A new result only appears if one was waiting in the last datapath stage.
    `RK4CP_ASSERT_SAME(a_no_invent, $rose(m_tvalid), $past(vp_reg[P_F2]), "result from nowhere")
    // Every accepted transaction occupies the first stage on the next cycle.
    `RK4CP_ASSERT_NEXT(a_accept_loads, s_tvalid && s_tready, vp_reg[0], "item not captured")

endmodule

// ===== sv/rk4cp_deriv.sv =====
// ---------------------------------------------------------------------------
// RK4 plant derivative pipeline
// Nine-stage pipeline computing the eight-element plant derivative.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rk4cp_deriv (
    input  logic               aclk,
    input  logic               en,
    input  rk4cp_pkg::vec_t    x_i,
    input  rk4cp_pkg::word_t   drive_a_i,
    input  rk4cp_pkg::word_t   drive_b_i,
    input  logic [20:0]        gravity_i,
    input  logic [17:0]        plant_gain_i,
    output rk4cp_pkg::vec_t    d_o,
    output logic               clip_o
);
    import rk4cp_pkg::*;

    vec_t                   pt_reg [1:DERIV_LAT];
    vec_t                   pt_next;
    word_t                  lane_d [NUM_LANES];
    logic [NUM_LANES-1:0]   lane_clip;

    // The simple derivative terms only ride along the pipeline.
    always_comb begin
        pt_next    = '0;
        pt_next[0] = x_i[1];
        pt_next[2] = x_i[3];
        pt_next[3] = drive_a_i;
        pt_next[4] = x_i[5];
        pt_next[6] = x_i[7];
        pt_next[7] = drive_b_i;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pt_reg[1] <= pt_next;
            for (int s = 2; s <= DERIV_LAT; s++) begin
                pt_reg[s] <= pt_reg[s-1];
            end
        end
    end

    for (genvar ln = 0; ln < NUM_LANES; ln++) begin : g_lane
        word_t   op_p, op_r, op_q, op_s, op_o, op_ang;
        sat_t    rr_c, qs_c, t1_c, t2_c, t3_c, sum_c, dv_c;
        word_t   ph_c, sin_c;
        cordic_t c0_c;
        cordic_t cn_c [3:6];

        word_t   rr_reg, qs_reg, p1_reg, o1_reg, ph_reg;
        word_t   t1_reg [2:7];
        word_t   t2_reg [2:7];
        cordic_t cd_reg [2:6];
        logic [8:1] clip_reg;
        word_t   t3_reg, sum_reg, dv_reg;
        logic    dclip_reg;

        if (ln == 0) begin : g_ops_a
            assign op_p   = x_i[0];
            assign op_r   = x_i[3];
            assign op_q   = x_i[4];
            assign op_ang = x_i[2];
        end else begin : g_ops_b
            assign op_p   = x_i[4];
            assign op_r   = x_i[7];
            assign op_q   = x_i[0];
            assign op_ang = x_i[6];
        end
        assign op_s = x_i[3];
        assign op_o = x_i[7];

        always_comb begin
            logic signed [63:0] ph_prod;
            logic signed [63:0] z_prod;
            logic signed [32:0] v;
            logic signed [33:0] yr;
            // Stage 1: squares/cross products and the angle-to-phase product.
            rr_c    = mulr(smul(op_r, op_r), 1'b0);
            qs_c    = mulr(smul(op_q, op_s), 1'b0);
            ph_prod = smul(op_ang, INV_TWO_PI_Q32);
            ph_c    = ph_prod[FRAC_BITS +: WORD_W];
            // Stage 2: third-order terms; fold phase to a quarter turn.
            t1_c = mulr(smul(rr_reg, p1_reg), 1'b0);
            t2_c = mulr(smul(qs_reg, o1_reg), 1'b0);
            v    = 33'(ph_reg);
            if (v > FOLD_LIMIT) begin
                v = HALF_TURN - v;
            end else if (v < -FOLD_LIMIT) begin
                v = -HALF_TURN - v;
            end
            z_prod  = 64'(v) * HALF_PI_Q29;
            c0_c.cx = CORDIC_K;
            c0_c.cy = '0;
            c0_c.cz = z_prod[29 +: 34];
            // Stages 3 to 6: four rotations each.
            for (int s = 3; s <= 6; s++) begin
                cn_c[s] = cd_reg[s-1];
                for (int j = 0; j < ITERS_PER_STAGE; j++) begin
                    cn_c[s] = cordic_rot(cn_c[s], 4'((s - 3) * ITERS_PER_STAGE + j));
                end
            end
            // Stage 7: round the sine and scale by gravity.
            yr    = cd_reg[6].cy + SIN_ROUND;
            sin_c = 32'(yr >>> (30 - FRAC_BITS));
            t3_c  = mulr(smul({11'd0, gravity_i}, sin_c), 1'b0);
            // Stage 8 and 9: bracket sum, then the plant gain.
            sum_c = sat48(48'(t1_reg[7]) + 48'(t2_reg[7]) - 48'(t3_reg));
            dv_c  = mulr(smul({14'd0, plant_gain_i}, sum_reg), 1'b0);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rr_reg      <= rr_c.val;
                qs_reg      <= qs_c.val;
                p1_reg      <= op_p;
                o1_reg      <= op_o;
                ph_reg      <= ph_c;
                clip_reg[1] <= rr_c.clip | qs_c.clip;
                t1_reg[2]   <= t1_c.val;
                t2_reg[2]   <= t2_c.val;
                cd_reg[2]   <= c0_c;
                clip_reg[2] <= clip_reg[1] | t1_c.clip | t2_c.clip;
                for (int s = 3; s <= 7; s++) begin
                    t1_reg[s] <= t1_reg[s-1];
                    t2_reg[s] <= t2_reg[s-1];
                end
                for (int s = 3; s <= 6; s++) begin
                    cd_reg[s]   <= cn_c[s];
                    clip_reg[s] <= clip_reg[s-1];
                end
                t3_reg      <= t3_c.val;
                clip_reg[7] <= clip_reg[6] | t3_c.clip;
                sum_reg     <= sum_c.val;
                clip_reg[8] <= clip_reg[7] | sum_c.clip;
                dv_reg      <= dv_c.val;
                dclip_reg   <= clip_reg[8] | dv_c.clip;
            end
        end

        assign lane_d[ln]    = dv_reg;
        assign lane_clip[ln] = dclip_reg;
    end

    always_comb begin
        d_o    = pt_reg[DERIV_LAT];
        d_o[1] = lane_d[0];
        d_o[5] = lane_d[1];
        clip_o = |lane_clip;
    end

endmodule

// ===== dv/testbench.sv =====
// ---------------------------------------------------------------------------
// RK4 coupled plant step testbench
// Drives plant states and drives into the stream input. A local copy of the
// fixed-point RK4 arithmetic predicts each stepped state, and every output
// transaction is checked against it field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import rk4cp_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 60;

    // An index past the last configuration register.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic signed [31:0] st [8];
        logic               clip;
    } step_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [319:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [255:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_wr_en = 1'b0;
    logic [1:0]   cfg_index = REG_STEP_WIDTH;
    logic [20:0]  cfg_wdata = '0;

    step_result_t expected_steps [$];
    int           error_count = 0;
    int           cycle_count = 0;
    int           rx_gap = 0;
    longint       h_reg, g_reg, gain_reg;
    logic         clip_flag;
    bit           no_stall = 1'b0;

    rk4_coupled_plant_step dut (.*);

    always #2 aclk = ~aclk;

    // A generous cycle budget. The slowest run has every transaction
    // waiting out the longest gap on both sides plus the pipeline latency.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Fixed-point predictor. Every intermediate saturates to 32 bits
    // and any clip raises the saturated flag of the step.
    // ---------------------------------------------------------------
    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) begin
            clip_flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            clip_flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Rounded product: the exact product fits 64 bits for 32-bit operands.
    function automatic longint qmul(longint a, longint b, int extra);
        int s;
        s = FRAC_BITS + extra;
        return clip32(fshr(a * b + (64'sd1 << (s - 1)), s));
    endfunction

    function automatic longint cordic_sine(longint ang);
        longint t, v, x, y, z, nx;
        t = fshr(ang * 683565276, FRAC_BITS);
        v = t & 64'hFFFF_FFFF;
        x = 652032874;
        y = 0;
        if (v >= 64'sh8000_0000) v -= 64'sh1_0000_0000;
        // Fold the phase into a quarter turn either side of zero.
        if (v > (64'sd1 << 30)) v = (64'sd1 << 31) - v;
        else if (v < -(64'sd1 << 30)) v = -(64'sd1 << 31) - v;
        z = fshr(v * 843314857, 29);
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - fshr(y, i);
                y  = y + fshr(x, i);
                z -= longint'(ATAN_Q30[i]);
            end else begin
                nx = x + fshr(y, i);
                y  = y - fshr(x, i);
                z += longint'(ATAN_Q30[i]);
            end
            x = nx;
        end
        return fshr(y + (64'sd1 << (29 - FRAC_BITS)), 30 - FRAC_BITS);
    endfunction

    function automatic longint coupled_accel(longint p, longint r, longint q,
                                             longint s, longint o, longint ang);
        longint t1, t2, t3;
        t1 = qmul(qmul(r, r, 0), p, 0);
        t2 = qmul(qmul(q, s, 0), o, 0);
        t3 = qmul(g_reg, cordic_sine(ang), 0);
        return qmul(gain_reg, clip32(t1 + t2 - t3), 0);
    endfunction

    function automatic void plant_deriv(input longint x [8], input longint ux,
                                        input longint uy, output longint d [8]);
        d[0] = x[1];
        d[1] = coupled_accel(x[0], x[3], x[4], x[3], x[7], x[2]);
        d[2] = x[3];
        d[3] = ux;
        d[4] = x[5];
        d[5] = coupled_accel(x[4], x[7], x[0], x[3], x[7], x[6]);
        d[6] = x[7];
        d[7] = uy;
    endfunction

    function automatic step_result_t predict_step(logic [319:0] item);
        longint x [8], pt [8], k1 [8], k2 [8], k3 [8], k4 [8];
        longint ux, uy, sum, q;
        step_result_t res;
        clip_flag = 1'b0;
        for (int i = 0; i < 8; i++) x[i] = longint'($signed(item[32*i +: 32]));
        ux = longint'($signed(item[256 +: 32]));
        uy = longint'($signed(item[288 +: 32]));
        plant_deriv(x, ux, uy, k1);
        for (int i = 0; i < 8; i++) pt[i] = clip32(x[i] + qmul(h_reg, k1[i], 1));
        plant_deriv(pt, ux, uy, k2);
        for (int i = 0; i < 8; i++) pt[i] = clip32(x[i] + qmul(h_reg, k2[i], 1));
        plant_deriv(pt, ux, uy, k3);
        for (int i = 0; i < 8; i++) pt[i] = clip32(x[i] + qmul(h_reg, k3[i], 0));
        plant_deriv(pt, ux, uy, k4);
        for (int i = 0; i < 8; i++) begin
            sum = k1[i] + 2 * k2[i] + 2 * k3[i] + k4[i];
            // h*sum stays under 2^53, so the floor divide is exact.
            q = h_reg * sum + (64'sd3 << FRAC_BITS);
            if (q >= 0) q = q / (64'sd6 << FRAC_BITS);
            else q = -((-q + (64'sd6 << FRAC_BITS) - 1) / (64'sd6 << FRAC_BITS));
            res.st[i] = clip32(x[i] + q);
        end
        res.clip = clip_flag;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Driving. tvalid stays high between back-to-back transactions and
    // drops only for an idle gap or before the input goes quiet.
    // ---------------------------------------------------------------
    task automatic send_state(logic [319:0] item);
        int gap;
        gap = no_stall ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        expected_steps.push_back(predict_step(item));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Waits for every result, then for the pipeline to drain, before a
    // register write; the block must be idle while it is reconfigured.
    task automatic write_reg(logic [1:0] idx, logic [20:0] val);
        s_tvalid <= 1'b0;
        while (expected_steps.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_STEP_WIDTH: h_reg    = val & 21'h1FFFF;
            REG_GRAVITY:    g_reg    = val;
            REG_PLANT_GAIN: gain_reg = val & 21'h3FFFF;
            default: ;
        endcase
    endtask

    // Receiver: after each output transaction it waits a random number of
    // cycles before taking the next one, checking each transaction.
    always @(posedge aclk) begin
        step_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_steps.size() == 0) begin
                $error("unexpected output transaction");
                error_count++;
            end else begin
                want = expected_steps.pop_front();
                for (int i = 0; i < 8; i++)
                    if ($signed(m_tdata[32*i +: 32]) !== want.st[i]) begin
                        $error("next state %0d: expected %0d, actual %0d",
                               i, want.st[i], $signed(m_tdata[32*i +: 32]));
                        error_count++;
                    end
                if (m_tuser[0] !== want.clip) begin
                    $error("saturated: expected %0b, actual %0b",
                           want.clip, m_tuser[0]);
                    error_count++;
                end
            end
            rx_gap = no_stall ? 0 : $urandom_range(0, 7);
        end else if (rx_gap > 0) begin
            rx_gap--;
        end
        m_tready <= (rx_gap == 0);
    end

    function automatic logic [31:0] rand_word(int kind);
        case (kind)
            0: return $urandom();
            1: return $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
            default: return $urandom_range(0, 32'h0000_4000) - 32'h0000_2000;
        endcase
    endfunction

    function automatic logic [319:0] rand_item(int kind);
        logic [319:0] v;
        for (int i = 0; i < 10; i++) v[32*i +: 32] = rand_word(kind);
        return v;
    endfunction

    // ---------------------------------------------------------------
    // Tests.
    // ---------------------------------------------------------------
    task automatic test_directed();
        logic [319:0] v;
        send_state('0);
        send_state({10{32'h7FFF_FFFF}});
        send_state({10{32'h8000_0000}});
        send_state({10{32'hFFFF_FFFF}});
        send_state({10{32'h0001_0000}});
        // Angles near a quarter, a half and three quarters of a turn exercise the sine fold.
        v = '0;
        v[64 +: 32]  = 32'h0001_921F;
        v[192 +: 32] = 32'hFFFC_DBC1;
        send_state(v);
        v[64 +: 32]  = 32'h0003_243F;
        v[192 +: 32] = 32'h0004_B65F;
        send_state(v);
        for (int i = 0; i < 6; i++) send_state(rand_item(0));
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            no_stall = (i % 100) < 10;
            send_state(rand_item($urandom_range(0, 2)));
        end
        no_stall = 1'b0;
    endtask

    task automatic test_config_sweep();
        write_reg(REG_STEP_WIDTH, 21'd0);
        write_reg(REG_GRAVITY, 21'd0);
        write_reg(REG_PLANT_GAIN, 21'd0);
        test_random(40);
        write_reg(REG_STEP_WIDTH, 21'd65536);
        write_reg(REG_GRAVITY, 21'd1310720);
        write_reg(REG_PLANT_GAIN, 21'd131072);
        test_directed();
        test_random(60);
        // An index past the last register is ignored.
        write_reg(REG_UNUSED, 21'h1F_FFFF);
        write_reg(REG_STEP_WIDTH, $urandom_range(0, 65536));
        write_reg(REG_GRAVITY, $urandom_range(0, 1310720));
        write_reg(REG_PLANT_GAIN, $urandom_range(0, 131072));
        test_random(60);
        write_reg(REG_STEP_WIDTH, STEP_WIDTH_RST);
        write_reg(REG_GRAVITY, GRAVITY_RST);
        write_reg(REG_PLANT_GAIN, PLANT_GAIN_RST);
    endtask

    initial begin
        h_reg    = STEP_WIDTH_RST;
        g_reg    = GRAVITY_RST;
        gain_reg = PLANT_GAIN_RST;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(400);
        test_config_sweep();
        test_random(60);
        s_tvalid <= 1'b0;
        while (expected_steps.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
